[hw/rtl/sorted_list_table_core_defines.svh]
// sorted_list_table_core_defines.svh
// assertion macros for the sorted list table core; no dependencies

`ifndef SORTED_LIST_TABLE_CORE_DEFINES_SVH
`define SORTED_LIST_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLT_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("sorted list table check failed");

// next-cycle implication, checked outside reset
`define SLT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("sorted list table check failed");

`endif

[hw/rtl/slt_pkg.sv]
// slt_pkg.sv
// command and status codes, default sizes and cell interface types
// used by slt_cell and sorted_list_table_core; no dependencies

package slt_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int PORT_KEY_W    = 32;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_SEARCH = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_REWIND = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_AT_END    = 2'd3;

  // broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } ctl_t;

  // per-cell compare results
  typedef struct packed {
    logic lt;        // stored key below the command key
    logic eq;        // stored key equals the command key
    logic first_eq;  // first equal key in the row
    logic ins_here;  // insert point
  } flags_t;

endpackage

[hw/rtl/sorted_list_table_core.sv]
// channel  | signals                              | transfer
// ---------+--------------------------------------+---------------------------
// command  | start, busy, cmd[2:0], key[31:0]     | start && !busy at clk edge
// result   | done, status, found, item, at_end,   | done high for one cycle
//          | count                                |
//
// each command's result shows on the result ports in the cycle after the
// transfer; done is high for that one cycle, the rest hold to the next transfer.
// busy stays low: the row of cells updates all slots in the transfer cycle,
// so a command may be given every cycle.
// rst is synchronous active high and clears count, cursor and done; stored
// keys come up undefined. the receiver cannot stall the result.
// depends on slt_pkg, slt_cell and sorted_list_table_core_defines.svh

`include "sorted_list_table_core_defines.svh"

module sorted_list_table_core #(
  parameter int CAPACITY  = slt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = slt_pkg::KEY_WIDTH_DEF,
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int PW  = slt_pkg::PORT_KEY_W,
  localparam int KW  = (KEY_WIDTH < PW) ? KEY_WIDTH : PW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    cmd,
  input  logic [PW-1:0] key,
  output logic          done,
  output logic [1:0]    status,
  output logic          found,
  output logic [PW-1:0] item,
  output logic          at_end,
  output logic [CW-1:0] count
);

  logic [KW-1:0]   cmd_key;
  logic [CW-1:0]   count_reg, count_next;
  logic [CW-1:0]   cursor_reg, cursor_next;
  logic [1:0]      status_next;
  logic            found_next;
  logic [KW-1:0]   item_next;
  logic            accept;
  logic            full;
  slt_pkg::ctl_t   ctl;

  logic [KW-1:0]   cell_key [CAPACITY];
  logic [KW-1:0]   cell_rd  [CAPACITY];
  slt_pkg::flags_t cell_flags [CAPACITY];

  logic            any_eq;
  logic [CW-1:0]   pos_eq, pos_ins;
  logic [KW-1:0]   rd_key;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign cmd_key = key[KW-1:0];
  assign full    = count_reg == CW'(CAPACITY);

  assign ctl.ins = accept && (cmd == slt_pkg::CMD_INSERT) && !full;
  assign ctl.rem = accept && (cmd == slt_pkg::CMD_REMOVE) && any_eq;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slt_cell #(
      .KW(KW), .CW(CW), .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key_in   (cmd_key),
      .count    (count_reg),
      .cursor   (cursor_reg),
      .left_lt  ((i == 0) ? 1'b1 : cell_flags[(i == 0) ? 0 : i - 1].lt),
      .left_key (cell_key[(i == 0) ? 0 : i - 1]),
      .right_key(cell_key[(i == CAPACITY - 1) ? i : i + 1]),
      .key      (cell_key[i]),
      .flags    (cell_flags[i]),
      .rd_key   (cell_rd[i])
    );
  end

  // one-hot selects, so the positions and read data fold with plain ors
  always_comb begin
    any_eq  = 1'b0;
    pos_eq  = '0;
    pos_ins = '0;
    rd_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq = any_eq | cell_flags[i].eq;
      if (cell_flags[i].first_eq) pos_eq = pos_eq | CW'(i);
      if (cell_flags[i].ins_here) pos_ins = pos_ins | CW'(i);
      rd_key = rd_key | cell_rd[i];
    end
  end

  always_comb begin
    count_next  = count_reg;
    cursor_next = cursor_reg;
    status_next = slt_pkg::ST_OK;
    found_next  = 1'b0;
    item_next   = '0;
    case (cmd)
      slt_pkg::CMD_INSERT: begin
        if (full) begin
          status_next = slt_pkg::ST_FULL;
        end else begin
          count_next  = count_reg + 1'b1;
          cursor_next = pos_ins;
        end
      end
      slt_pkg::CMD_SEARCH: begin
        if (any_eq) begin
          cursor_next = pos_eq;
          found_next  = 1'b1;
        end else begin
          cursor_next = count_reg;
          status_next = slt_pkg::ST_NOT_FOUND;
        end
      end
      slt_pkg::CMD_REMOVE: begin
        if (any_eq) begin
          count_next  = count_reg - 1'b1;
          cursor_next = pos_eq;
          found_next  = 1'b1;
        end else begin
          cursor_next = count_reg;
          status_next = slt_pkg::ST_NOT_FOUND;
        end
      end
      slt_pkg::CMD_REWIND: begin
        cursor_next = '0;
      end
      slt_pkg::CMD_READ: begin
        if (cursor_reg < count_reg) begin
          item_next   = rd_key;
          cursor_next = cursor_reg + 1'b1;
        end else begin
          status_next = slt_pkg::ST_AT_END;
        end
      end
      slt_pkg::CMD_CLEAR: begin
        count_next  = '0;
        cursor_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg  <= '0;
      cursor_reg <= '0;
      done       <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count_reg  <= count_next;
        cursor_reg <= cursor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      found  <= found_next;
      item   <= PW'(item_next);
      at_end <= cursor_next >= count_next;
      count  <= count_next;
    end
  end

  `SLT_ASSERT_NEXT(a_done_follows, clk, rst, accept, done)
  `SLT_ASSERT_NOW(a_cursor_in_range, clk, rst, 1'b1, cursor_reg <= count_reg)
  `SLT_ASSERT_NOW(a_count_in_range, clk, rst, done, count <= CW'(CAPACITY))
  `SLT_ASSERT_NEXT(a_insert_grows, clk, rst, ctl.ins, count_reg == $past(count_reg) + 1'b1)

endmodule

[hw/rtl/slt_cell.sv]
// slt_cell.sv
// one slot of the sorted row: holds a key, compares it, shifts left or right
// depends on slt_pkg

module slt_cell #(
  parameter int KW    = slt_pkg::KEY_WIDTH_DEF,
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  slt_pkg::ctl_t      ctl,
  input  logic [KW-1:0]      key_in,
  input  logic [CW-1:0]      count,
  input  logic [CW-1:0]      cursor,
  input  logic               left_lt,
  input  logic [KW-1:0]      left_key,
  input  logic [KW-1:0]      right_key,
  output logic [KW-1:0]      key,
  output slt_pkg::flags_t    flags,
  output logic [KW-1:0]      rd_key
);

  logic used;

  assign used           = CW'(INDEX) < count;
  assign flags.lt       = used && (key < key_in);
  assign flags.eq       = used && (key == key_in);
  // equal keys form one run, so the first one has a smaller key on its left
  assign flags.first_eq = flags.eq && left_lt;
  assign flags.ins_here = !flags.lt && left_lt;
  assign rd_key         = (CW'(INDEX) == cursor) ? key : '0;

  // slots past the count take whatever comes, they are never read
  always_ff @(posedge clk) begin
    if (ctl.ins && !flags.lt) begin
      key <= left_lt ? key_in : left_key;
    end else if (ctl.rem && !flags.lt) begin
      key <= right_key;
    end
  end

endmodule
